### rtl/core/resizing_stack_tracker_macros.svh
// Assertion macros shared by the resizing stack tracker RTL.
`ifndef RESIZING_STACK_TRACKER_MACROS_SVH
`define RESIZING_STACK_TRACKER_MACROS_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define RST_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset.
`define RST_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/core/rst_pkg.sv
// Shared types and constants for the resizing stack tracker.
`default_nettype none
package rst_pkg;

   localparam int CAP_W               = 11;
   localparam int WORD_WIDTH_DEFAULT  = 32;
   localparam int STACK_DEPTH_DEFAULT = 1024;
   localparam int DATA_W              = 32;
   localparam int TALLY_W             = 32;
   localparam int RSP_TDATA_W         = 104;
   localparam int RSP_TUSER_W         = 2;

   localparam logic [CAP_W-1:0]  CAP_LIMIT     = 11'd2047;
   localparam logic [CAP_W-1:0]  MIN_CAP_RESET = 11'd10;
   localparam logic [DATA_W-1:0] EMPTY_CODE    = 32'hFFFF_FF9D;

   typedef logic [CAP_W-1:0] cap_type;

   typedef enum logic {
      OP_PUSH = 1'b0,
      OP_POP  = 1'b1
   } op_type;

   // Outcome of the capacity policy for one transaction.
   typedef struct packed {
      logic    resized;
      cap_type cap;
      cap_type peak;
   } resize_type;

endpackage
`default_nettype wire

### rtl/core/rst_resize.sv
// Capacity grow/shrink policy for one push or non-empty pop.
`default_nettype none
module rst_resize #(
   parameter int FILL_W = 11
) (
   input  logic               is_pop,
   input  logic [FILL_W-1:0]  fill,
   input  rst_pkg::cap_type   cap,
   input  rst_pkg::cap_type   peak,
   input  rst_pkg::cap_type   min_cap,
   output rst_pkg::resize_type result
);
   import rst_pkg::*;

   localparam int CMP_W = (FILL_W > CAP_W) ? FILL_W : CAP_W;

   logic [CMP_W-1:0] fill_x;
   logic [CMP_W-1:0] fill_p1;
   logic [CMP_W-1:0] top_x;
   logic [CMP_W-1:0] cap_x;
   logic [CMP_W-1:0] half_x;
   logic [CAP_W:0]   grow_sum;
   cap_type          grow_cap;
   cap_type          half_cap;
   cap_type          shrink_cap;
   logic             do_grow;
   logic             do_shrink;

   always_comb begin
      fill_x   = CMP_W'(fill);
      fill_p1  = fill_x + CMP_W'(1);
      top_x    = fill_x - CMP_W'(1);
      cap_x    = CMP_W'(cap);
      half_cap = cap >> 1;
      half_x   = CMP_W'(half_cap);

      grow_sum = {1'b0, cap} + {1'b0, half_cap};
      grow_cap = (grow_sum > {1'b0, CAP_LIMIT}) ? CAP_LIMIT : grow_sum[CAP_W-1:0];
      shrink_cap = (half_cap < min_cap) ? min_cap : half_cap;

      // pop checks grow before the decrement and shrink after it, push after the increment
      if (is_pop) begin
         do_grow   = fill_x >= cap_x;
         do_shrink = !do_grow && (top_x < half_x) && (cap > min_cap);
      end else begin
         do_grow   = fill_p1 >= cap_x;
         do_shrink = 1'b0;
      end

      result.resized = do_grow || do_shrink;
      if (do_grow) begin
         result.cap  = grow_cap;
         result.peak = (grow_cap > peak) ? grow_cap : peak;
      end else if (do_shrink) begin
         result.cap  = shrink_cap;
         result.peak = peak;
      end else begin
         result.cap  = cap;
         result.peak = peak;
      end
   end

endmodule
`default_nettype wire

### rtl/core/resizing_stack_tracker.sv
// Top level of the resizing stack tracker: stack memory, counters and stream ports.
//
// Usage:
//  - req channel: one transaction per operation. req_tuser[0] is the op (push/pop),
//    req_tdata carries the word to push (ignored on pop).
//  - rsp channel: one transaction per request, in order. It carries the popped
//    word, empty/overflow flags, occupancy, logical capacity, peak capacity
//    and the resize tally.
//  - csr: a write of min_capacity restarts the tracker (stack emptied, capacity
//    and peak set to the new minimum, tally cleared). Write only while idle.
// Response timing and throughput:
//  - push, overflowed push and empty pop: result goes to the output register,
//    one transaction per cycle while the output is not stalled.
//  - non-empty pop: the stack memory read is registered in rd_data_ff, then the
//    result goes to the output register; req_tready drops for the read cycle.
// Reset: synchronous, active high; empties the stack, min_capacity back to 10.
// Stall: the result waits in the output register; a new request is taken in the
// same cycle the waiting result is taken, otherwise req_tready stays low.
// The stack memory is never cleared; only written entries are ever read.
`default_nettype none
`include "resizing_stack_tracker_macros.svh"
module resizing_stack_tracker #(
   parameter int STACK_DEPTH = rst_pkg::STACK_DEPTH_DEFAULT,
   parameter int WORD_WIDTH  = rst_pkg::WORD_WIDTH_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   // request: tdata = value[31:0]; tuser = op[0]
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [rst_pkg::DATA_W-1:0]      req_tdata,
   input  logic [0:0]                      req_tuser,
   // response: tdata = pop_value[31:0], occupancy[42:32], capacity[53:43],
   //           peak_capacity[64:54], resize_count[96:65], zero pad[103:97]
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [rst_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   // response: tuser = was_empty[0], overflow[1]
   output logic [rst_pkg::RSP_TUSER_W-1:0] rsp_tuser,
   // config: min_capacity
   input  logic                            csr_wen,
   input  logic [rst_pkg::CAP_W-1:0]       csr_wdata
);
   import rst_pkg::*;

   localparam int ADDR_W = $clog2(STACK_DEPTH);
   localparam int FILL_W = $clog2(STACK_DEPTH + 1);
   localparam int PAD_W  = RSP_TDATA_W - DATA_W - 3 * CAP_W - TALLY_W;

   // stack memory, one write or one read per cycle
   logic [WORD_WIDTH-1:0] stack_mem [STACK_DEPTH];
   logic [WORD_WIDTH-1:0] rd_data_ff;

   // tracker state
   logic [FILL_W-1:0]  fill_ff,  fill_in;
   cap_type            cap_ff,   cap_in;
   cap_type            peak_ff,  peak_in;
   cap_type            min_ff,   min_in;
   logic [TALLY_W-1:0] tally_ff, tally_in;

   // response path
   logic               pend_ff,  pend_in;     // pop read in flight
   logic               rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]  rsp_value_ff, rsp_value_in;
   logic               rsp_empty_ff, rsp_empty_in;
   logic               rsp_ovf_ff,   rsp_ovf_in;

   logic               req_fire;
   op_type             req_op;
   logic               mem_full;
   logic               stack_empty;
   logic               mem_we;
   logic               mem_re;
   logic [ADDR_W-1:0]  mem_addr;
   resize_type         resize;

   assign req_op      = op_type'(req_tuser[0]);
   assign mem_full    = fill_ff == FILL_W'(STACK_DEPTH);
   assign stack_empty = fill_ff == '0;

   // output slot free or freeing, and no pop read outstanding
   assign req_tready = !pend_ff && (!rsp_valid_ff || rsp_tready);
   assign req_fire   = req_tvalid && req_tready;

   rst_resize #(
      .FILL_W (FILL_W)
   ) u_resize (
      .is_pop  (req_op == OP_POP),
      .fill    (fill_ff),
      .cap     (cap_ff),
      .peak    (peak_ff),
      .min_cap (min_ff),
      .result  (resize)
   );

   always_comb begin
      fill_in      = fill_ff;
      cap_in       = cap_ff;
      peak_in      = peak_ff;
      min_in       = min_ff;
      tally_in     = tally_ff;
      pend_in      = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_value_in = rsp_value_ff;
      rsp_empty_in = rsp_empty_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      mem_addr     = fill_ff[ADDR_W-1:0];

      if (pend_ff) begin
         // read data is back; state was already updated at acceptance
         rsp_valid_in = 1'b1;
         rsp_value_in = DATA_W'(rd_data_ff);
         rsp_empty_in = 1'b0;
         rsp_ovf_in   = 1'b0;
      end

      if (req_fire) begin
         unique case (req_op)
            OP_PUSH: begin
               rsp_valid_in = 1'b1;
               rsp_value_in = '0;
               rsp_empty_in = 1'b0;
               rsp_ovf_in   = mem_full;
               if (!mem_full) begin
                  mem_we   = 1'b1;
                  fill_in  = fill_ff + FILL_W'(1);
                  cap_in   = resize.cap;
                  peak_in  = resize.peak;
                  tally_in = tally_ff + TALLY_W'(resize.resized);
               end
            end
            OP_POP: begin
               if (stack_empty) begin
                  rsp_valid_in = 1'b1;
                  rsp_value_in = EMPTY_CODE;
                  rsp_empty_in = 1'b1;
                  rsp_ovf_in   = 1'b0;
               end else begin
                  // result goes out once the read data is back in rd_data_ff
                  rsp_valid_in = 1'b0;
                  mem_re       = 1'b1;
                  mem_addr     = ADDR_W'(fill_ff - FILL_W'(1));
                  pend_in      = 1'b1;
                  fill_in      = fill_ff - FILL_W'(1);
                  cap_in       = resize.cap;
                  peak_in      = resize.peak;
                  tally_in     = tally_ff + TALLY_W'(resize.resized);
               end
            end
            default: begin
               rsp_valid_in = rsp_valid_ff && !rsp_tready;
            end
         endcase
      end

      // restart on a new minimum
      if (csr_wen) begin
         min_in   = csr_wdata;
         fill_in  = '0;
         cap_in   = csr_wdata;
         peak_in  = csr_wdata;
         tally_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         stack_mem[mem_addr] <= WORD_WIDTH'($signed(req_tdata));
      end
      if (mem_re) begin
         rd_data_ff <= stack_mem[mem_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         cap_ff       <= MIN_CAP_RESET;
         peak_ff      <= MIN_CAP_RESET;
         min_ff       <= MIN_CAP_RESET;
         tally_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fill_ff      <= fill_in;
         cap_ff       <= cap_in;
         peak_ff      <= peak_in;
         min_ff       <= min_in;
         tally_ff     <= tally_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_value_ff <= rsp_value_in;
      rsp_empty_ff <= rsp_empty_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   // state holds while a result waits, so the counters feed the port directly
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{PAD_W{1'b0}}, tally_ff, peak_ff, cap_ff,
                        CAP_W'(fill_ff), rsp_value_ff};
   assign rsp_tuser  = {rsp_ovf_ff, rsp_empty_ff};

   `RST_ASSERT_IMP(a_pend_slot_free, pend_ff, !rsp_valid_ff,
      "pop read in flight while output slot is occupied")
   `RST_ASSERT_NXT(a_pop_reads, req_fire && req_op == OP_POP && !stack_empty,
      pend_ff && !rsp_valid_ff, "non-empty pop did not start a memory read")
   `RST_ASSERT_IMP(a_cap_floor, 1'b1, cap_ff >= min_ff,
      "capacity fell below the minimum")
   `RST_ASSERT_IMP(a_peak_bound, 1'b1, peak_ff >= cap_ff,
      "peak capacity below current capacity")
   `RST_ASSERT_IMP(a_fill_bound, 1'b1, fill_ff <= FILL_W'(STACK_DEPTH),
      "occupancy beyond physical depth")

endmodule
`default_nettype wire
